// ----- rtl/alss_pkg.sv -----
// ----------------------------------------------------------------------------
// alss_pkg
// Types, codes and constants shared by the link session scheduler.
// ----------------------------------------------------------------------------
package alss_pkg;

  localparam int TX_BUFFER_BYTES_DEF = 192;

  localparam int HELLO_LEN      = 20;
  localparam int SYNC_LEN       = 28;
  localparam int ACK_LEN        = 20;
  localparam int SYNC_REPLY_LEN = 44;
  localparam int ATTITUDE_LEN   = 62;

  localparam logic [15:0] ONLINE_TIMEOUT_RESET  = 16'd3000;
  localparam logic [7:0]  ATTITUDE_PERIOD_RESET = 8'd5;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_ONLINE_TIMEOUT  = 2'd0,
    REG_ATTITUDE_PERIOD = 2'd1
  } reg_index_t;

  typedef enum logic [1:0] {
    CMD_FRAME  = 2'd0,
    CMD_TICK   = 2'd1,
    CMD_LEGACY = 2'd2
  } command_t;

  typedef enum logic [1:0] {
    KIND_HELLO = 2'd0,
    KIND_SYNC  = 2'd1,
    KIND_OTHER = 2'd2
  } frame_kind_t;

  typedef enum logic [2:0] {
    SEND_NONE     = 3'd0,
    SEND_ACK      = 3'd1,
    SEND_SYNC     = 3'd2,
    SEND_ATTITUDE = 3'd3,
    SEND_LEGACY   = 3'd4
  } send_kind_t;

  typedef struct packed {
    command_t    command;
    logic [31:0] now_ms;
    logic [63:0] now_us;
    logic        frame_ok;
    frame_kind_t frame_kind;
    logic [7:0]  frame_len;
    logic [63:0] frame_session;
    logic [31:0] frame_sequence;
    logic [63:0] frame_t1;
    logic        uart_ready;
    logic [7:0]  legacy_len;
  } in_word_t;

  typedef struct packed {
    send_kind_t  send_kind;
    logic [31:0] out_sequence;
    logic [63:0] out_session;
    logic [63:0] echo_t1;
    logic [63:0] echo_t2;
    logic [63:0] reply_t3;
    logic        attitude_captured;
    logic [31:0] attitude_sequence;
    logic        online;
    logic        legacy_accepted;
  } out_word_t;

  typedef struct packed {
    logic        session_active;
    logic        ack_waiting;
    logic        sync_waiting;
    logic        attitude_waiting;
    logic [63:0] session_id;
    logic [63:0] partner_time;
    logic [63:0] receive_time;
    logic [31:0] last_request_tick;
    logic [31:0] last_capture_tick;
    logic [31:0] request_seq;
    logic [31:0] transmit_seq;
  } session_t;

  typedef struct packed {
    logic [15:0] online_timeout_ms;
    logic [7:0]  attitude_period_ms;
  } cfg_t;

endpackage

// ----- rtl/attitude_link_session_scheduler_unit.sv -----
// ----------------------------------------------------------------------------
// attitude_link_session_scheduler_unit
// Session side of a serial attitude link: hello, sync, ticks and legacy sends.
// ----------------------------------------------------------------------------
//  channel  | signals                         | direction
//  ---------+---------------------------------+----------
//  in       | in_valid, in_stall, in_word     | into block
//  out      | out_valid, out_stall, out_word  | out of block
//  cfg      | cfg_write, cfg_index, cfg_data  | into block
//
//  one word per clock unless the result stalls; a word moves from the input register
//  to the result register once the result register is free
//  session state updates in the same cycle, so the next word sees it at once
//  rst is synchronous and restores register defaults and an empty session
//  a stalled result holds and the input register fills behind it
// ----------------------------------------------------------------------------
module attitude_link_session_scheduler_unit #(
  parameter int TX_BUFFER_BYTES = alss_pkg::TX_BUFFER_BYTES_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  alss_pkg::in_word_t                 in_word,
  output logic                               out_valid,
  input  logic                               out_stall,
  output alss_pkg::out_word_t                out_word,
  input  logic                               cfg_write,
  input  logic [alss_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [alss_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import alss_pkg::*;

  logic      held_valid;
  in_word_t  held;
  session_t  st;
  session_t  st_next;
  cfg_t      cfg;
  out_word_t result;
  logic      advance;
  logic      in_take;

  assign advance  = held_valid && (!out_valid || !out_stall);
  assign in_stall = held_valid && !advance;
  assign in_take  = in_valid && !in_stall;

  alss_step #(
    .TX_BUFFER_BYTES(TX_BUFFER_BYTES)
  ) u_step (
    .st     (st),
    .cfg    (cfg),
    .item   (held),
    .st_next(st_next),
    .result (result)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_take) begin
      held_valid <= 1'b1;
    end else if (advance) begin
      held_valid <= 1'b0;
    end
    if (in_take) begin
      held <= in_word;
    end
  end

  // session state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= '0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        st        <= st_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
    if (advance) begin
      out_word <= result;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.online_timeout_ms  <= ONLINE_TIMEOUT_RESET;
      cfg.attitude_period_ms <= ATTITUDE_PERIOD_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_ONLINE_TIMEOUT:  cfg.online_timeout_ms  <= cfg_data;
        REG_ATTITUDE_PERIOD: cfg.attitude_period_ms <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  a_sync_needs_session: assert property (@(posedge clk) disable iff (rst)
    st.sync_waiting |-> st.session_active)
    else $error("sync reply pending without a session");

  a_frame_sent_online: assert property (@(posedge clk) disable iff (rst)
    (out_valid && ((out_word.send_kind == SEND_ACK) || (out_word.send_kind == SEND_SYNC) ||
                   (out_word.send_kind == SEND_ATTITUDE))) |-> out_word.online)
    else $error("session frame sent while offline");

  a_legacy_kind: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_word.legacy_accepted) |-> (out_word.send_kind == SEND_LEGACY))
    else $error("legacy grant without legacy send");

  a_capture_online: assert property (@(posedge clk) disable iff (rst)
    (advance && result.attitude_captured) |=> st.attitude_waiting || out_word.online)
    else $error("attitude captured while offline");

endmodule

// ----- rtl/alss_step.sv -----
// ----------------------------------------------------------------------------
// alss_step
// Next session state and result word for one input word.
// ----------------------------------------------------------------------------
module alss_step #(
  parameter int TX_BUFFER_BYTES = alss_pkg::TX_BUFFER_BYTES_DEF
) (
  input  alss_pkg::session_t  st,
  input  alss_pkg::cfg_t      cfg,
  input  alss_pkg::in_word_t  item,
  output alss_pkg::session_t  st_next,
  output alss_pkg::out_word_t result
);
  import alss_pkg::*;

  localparam logic ACK_FITS      = (ACK_LEN <= TX_BUFFER_BYTES);
  localparam logic SYNC_FITS     = (SYNC_REPLY_LEN <= TX_BUFFER_BYTES);
  localparam logic ATTITUDE_FITS = (ATTITUDE_LEN <= TX_BUFFER_BYTES);
  localparam logic [7:0] TX_MAX  = 8'(TX_BUFFER_BYTES);

  logic [31:0] timeout_w;
  logic [31:0] period_w;
  logic [31:0] since_request;
  logic [31:0] since_capture;
  logic        online_pre;

  assign timeout_w     = {16'd0, cfg.online_timeout_ms};
  assign period_w      = {24'd0, cfg.attitude_period_ms};
  assign since_request = item.now_ms - st.last_request_tick;
  assign since_capture = item.now_ms - st.last_capture_tick;
  assign online_pre    = st.session_active && (since_request < timeout_w);

  always_comb begin
    logic [31:0] seq_inc;
    logic        gap;
    logic [31:0] since_request_post;
    seq_inc = st.transmit_seq + 32'd1;
    gap     = 1'b0;
    st_next = st;
    result  = '0;
    result.send_kind = SEND_NONE;
    case (item.command)
      CMD_FRAME: begin
        if (item.frame_ok && (item.frame_session != 64'd0)) begin
          if ((item.frame_kind == KIND_HELLO) && (item.frame_len == 8'(HELLO_LEN))) begin
            if (!st.session_active || (st.session_id != item.frame_session)) begin
              st_next.transmit_seq      = '0;
              st_next.attitude_waiting  = 1'b0;
              st_next.last_capture_tick = item.now_ms;
            end
            st_next.session_id        = item.frame_session;
            st_next.session_active    = 1'b1;
            st_next.ack_waiting       = 1'b1;
            st_next.sync_waiting      = 1'b0;
            st_next.request_seq       = item.frame_sequence;
            st_next.last_request_tick = item.now_ms;
          end else if ((item.frame_kind == KIND_SYNC) && (item.frame_len == 8'(SYNC_LEN))
                       && online_pre && (item.frame_session == st.session_id)) begin
            st_next.request_seq       = item.frame_sequence;
            st_next.partner_time      = item.frame_t1;
            st_next.receive_time      = item.now_us;
            st_next.sync_waiting      = 1'b1;
            st_next.last_request_tick = item.now_ms;
          end
        end
      end
      CMD_TICK: begin
        if (!online_pre) begin
          st_next.session_active   = 1'b0;
          st_next.ack_waiting      = 1'b0;
          st_next.sync_waiting     = 1'b0;
          st_next.attitude_waiting = 1'b0;
        end else begin
          if (since_capture >= period_w) begin
            st_next.last_capture_tick = item.now_ms;
            st_next.transmit_seq      = seq_inc;
            st_next.attitude_waiting  = 1'b1;
            result.attitude_captured  = 1'b1;
            result.attitude_sequence  = seq_inc;
          end
          if (item.uart_ready) begin
            if (st.ack_waiting) begin
              if (ACK_FITS) begin
                st_next.ack_waiting = 1'b0;
                result.send_kind    = SEND_ACK;
                result.out_sequence = st.request_seq;
                result.out_session  = st.session_id;
              end
            end else if (st.sync_waiting) begin
              if (SYNC_FITS) begin
                st_next.sync_waiting = 1'b0;
                result.send_kind     = SEND_SYNC;
                result.out_sequence  = st.request_seq;
                result.out_session   = st.session_id;
                result.echo_t1       = st.partner_time;
                result.echo_t2       = st.receive_time;
                result.reply_t3      = item.now_us;
              end
            end else if (st_next.attitude_waiting) begin
              if (ATTITUDE_FITS) begin
                st_next.attitude_waiting = 1'b0;
                result.send_kind         = SEND_ATTITUDE;
                result.out_sequence      = st_next.transmit_seq;
                result.out_session       = st.session_id;
              end
            end
          end
        end
      end
      CMD_LEGACY: begin
        if ((item.legacy_len != 8'd0) && (item.legacy_len <= TX_MAX)) begin
          gap = !st.ack_waiting && !st.sync_waiting && !st.attitude_waiting
                && (since_capture < period_w);
          if ((!online_pre || gap) && item.uart_ready) begin
            result.send_kind       = SEND_LEGACY;
            result.legacy_accepted = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
    since_request_post = item.now_ms - st_next.last_request_tick;
    result.online      = st_next.session_active && (since_request_post < timeout_w);
  end

endmodule

// ----- tb/alss_link_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// alss_link_checker
// Watches both channels and the register port of the session scheduler,
// predicts the result word of every accepted input word from its own copy of
// the session state and registers, and compares each result word in order.
// ----------------------------------------------------------------------------
module alss_link_checker #(
  parameter int TX_BYTES = alss_pkg::TX_BUFFER_BYTES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  input  logic                             in_stall,
  input  alss_pkg::in_word_t               in_word,
  input  logic                             out_valid,
  input  logic                             out_stall,
  input  alss_pkg::out_word_t              out_word,
  input  logic                             cfg_write,
  input  logic [alss_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [alss_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                               words_due,
  output int                               mismatches
);

  import alss_pkg::*;

  session_t  link;
  cfg_t      regs;
  out_word_t pending_replies[$];

  function automatic logic link_up(input logic [31:0] now_ms);
    logic [31:0] since;
    since = now_ms - link.last_request_tick;
    return link.session_active && (since < {16'd0, regs.online_timeout_ms});
  endfunction

  task automatic predict_session_step(input in_word_t w, output out_word_t r);
    logic [31:0] since_capture;
    logic        gap;
    r = '0;
    since_capture = w.now_ms - link.last_capture_tick;
    if (w.command == CMD_FRAME) begin
      if (w.frame_ok && w.frame_session != 64'd0) begin
        if (w.frame_kind == KIND_HELLO && w.frame_len == 8'(HELLO_LEN)) begin
          if (!link.session_active || link.session_id != w.frame_session) begin
            link.transmit_seq      = '0;
            link.attitude_waiting  = 1'b0;
            link.last_capture_tick = w.now_ms;
          end
          link.session_id        = w.frame_session;
          link.session_active    = 1'b1;
          link.ack_waiting       = 1'b1;
          link.sync_waiting      = 1'b0;
          link.request_seq       = w.frame_sequence;
          link.last_request_tick = w.now_ms;
        end else if (w.frame_kind == KIND_SYNC && w.frame_len == 8'(SYNC_LEN) &&
                     link_up(w.now_ms) && w.frame_session == link.session_id) begin
          link.request_seq       = w.frame_sequence;
          link.partner_time      = w.frame_t1;
          link.receive_time      = w.now_us;
          link.sync_waiting      = 1'b1;
          link.last_request_tick = w.now_ms;
        end
      end
    end else if (w.command == CMD_TICK) begin
      if (!link_up(w.now_ms)) begin
        link.session_active   = 1'b0;
        link.ack_waiting      = 1'b0;
        link.sync_waiting     = 1'b0;
        link.attitude_waiting = 1'b0;
      end else begin
        if (since_capture >= {24'd0, regs.attitude_period_ms}) begin
          link.last_capture_tick = w.now_ms;
          link.transmit_seq      = link.transmit_seq + 32'd1;
          link.attitude_waiting  = 1'b1;
          r.attitude_captured    = 1'b1;
          r.attitude_sequence    = link.transmit_seq;
        end
        if (w.uart_ready) begin
          if (link.ack_waiting) begin
            if (ACK_LEN <= TX_BYTES) begin
              link.ack_waiting = 1'b0;
              r.send_kind      = SEND_ACK;
              r.out_sequence   = link.request_seq;
              r.out_session    = link.session_id;
            end
          end else if (link.sync_waiting) begin
            if (SYNC_REPLY_LEN <= TX_BYTES) begin
              link.sync_waiting = 1'b0;
              r.send_kind       = SEND_SYNC;
              r.out_sequence    = link.request_seq;
              r.out_session     = link.session_id;
              r.echo_t1         = link.partner_time;
              r.echo_t2         = link.receive_time;
              r.reply_t3        = w.now_us;
            end
          end else if (link.attitude_waiting) begin
            if (ATTITUDE_LEN <= TX_BYTES) begin
              link.attitude_waiting = 1'b0;
              r.send_kind           = SEND_ATTITUDE;
              r.out_sequence        = link.transmit_seq;
              r.out_session         = link.session_id;
            end
          end
        end
      end
    end else if (w.command == CMD_LEGACY) begin
      if (w.legacy_len != 8'd0 && w.legacy_len <= TX_BYTES) begin
        gap = !link.ack_waiting && !link.sync_waiting && !link.attitude_waiting &&
              (since_capture < {24'd0, regs.attitude_period_ms});
        if ((!link_up(w.now_ms) || gap) && w.uart_ready) begin
          r.send_kind       = SEND_LEGACY;
          r.legacy_accepted = 1'b1;
        end
      end
    end
    r.online = link_up(w.now_ms);
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : watch
    out_word_t want;
    out_word_t next_reply;
    if (rst) begin
      link = '0;
      regs.online_timeout_ms  = ONLINE_TIMEOUT_RESET;
      regs.attitude_period_ms = ATTITUDE_PERIOD_RESET;
      pending_replies.delete();
    end else begin
      if (cfg_write) begin
        if (cfg_index == REG_ONLINE_TIMEOUT) regs.online_timeout_ms = cfg_data[15:0];
        else if (cfg_index == REG_ATTITUDE_PERIOD) regs.attitude_period_ms = cfg_data[7:0];
      end
      if (out_valid && !out_stall) begin
        if (pending_replies.size() == 0) begin
          $display("%0t: result word with none expected, actual %0h", $time, out_word);
          mismatches++;
        end else begin
          want = pending_replies.pop_front();
          check_field("send_kind", want.send_kind, out_word.send_kind);
          check_field("out_sequence", want.out_sequence, out_word.out_sequence);
          check_field("out_session", want.out_session, out_word.out_session);
          check_field("echo_t1", want.echo_t1, out_word.echo_t1);
          check_field("echo_t2", want.echo_t2, out_word.echo_t2);
          check_field("reply_t3", want.reply_t3, out_word.reply_t3);
          check_field("attitude_captured", want.attitude_captured,
                      out_word.attitude_captured);
          check_field("attitude_sequence", want.attitude_sequence,
                      out_word.attitude_sequence);
          check_field("online", want.online, out_word.online);
          check_field("legacy_accepted", want.legacy_accepted, out_word.legacy_accepted);
        end
      end
      if (in_valid && !in_stall) begin
        predict_session_step(in_word, next_reply);
        pending_replies.push_back(next_reply);
      end
    end
    words_due = pending_replies.size();
  end

endmodule

// ----- tb/attitude_link_session_scheduler_unit_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// attitude_link_session_scheduler_unit_tb
// Drives hello, sync, tick and legacy words into the session scheduler with
// random gaps and stalls, a long output hold-off and drained phases under
// several register settings; the checker beside the block judges each word.
// ----------------------------------------------------------------------------
module attitude_link_session_scheduler_unit_tb;

  import alss_pkg::*;

  localparam int          TX_BYTES       = TX_BUFFER_BYTES_DEF;
  localparam int          HOLD_CYCLES    = 80;
  localparam int          WATCHDOG_LIMIT = 2000;
  localparam command_t    CMD_UNUSED     = command_t'(2'd3);
  localparam frame_kind_t KIND_SPARE     = frame_kind_t'(2'd3);

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid;
  logic                   in_stall;
  in_word_t               in_word;
  logic                   out_valid;
  logic                   out_stall;
  out_word_t              out_word;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  int                     words_due;
  int                     mismatches;

  logic [31:0] clk_ms;
  logic [63:0] clk_us;
  logic [63:0] link_session;
  logic        send_idle;
  logic        recv_idle;
  int          hold_reqs;

  attitude_link_session_scheduler_unit #(.TX_BUFFER_BYTES(TX_BYTES)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  alss_link_checker #(.TX_BYTES(TX_BYTES)) u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .words_due(words_due), .mismatches(mismatches)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // random fill so that unused fields still toggle
  function automatic in_word_t base_word(input command_t c);
    logic [319:0] bits;
    in_word_t     w;
    for (int k = 0; k < 320; k += 32) bits[k +: 32] = $urandom;
    w = in_word_t'(bits[$bits(in_word_t)-1:0]);
    w.command = c;
    w.now_ms  = clk_ms;
    w.now_us  = clk_us;
    return w;
  endfunction

  function automatic in_word_t tick_word(input logic ready);
    in_word_t w;
    w = base_word(CMD_TICK);
    w.uart_ready = ready;
    return w;
  endfunction

  function automatic in_word_t legacy_word(input logic [7:0] len, input logic ready);
    in_word_t w;
    w = base_word(CMD_LEGACY);
    w.legacy_len = len;
    w.uart_ready = ready;
    return w;
  endfunction

  function automatic in_word_t hello_word(input logic [63:0] sess, input logic [31:0] seq);
    in_word_t w;
    w = base_word(CMD_FRAME);
    w.frame_ok       = 1'b1;
    w.frame_kind     = KIND_HELLO;
    w.frame_len      = 8'(HELLO_LEN);
    w.frame_session  = sess;
    w.frame_sequence = seq;
    return w;
  endfunction

  function automatic in_word_t sync_word(input logic [63:0] sess, input logic [31:0] seq,
                                         input logic [63:0] t1);
    in_word_t w;
    w = base_word(CMD_FRAME);
    w.frame_ok       = 1'b1;
    w.frame_kind     = KIND_SYNC;
    w.frame_len      = 8'(SYNC_LEN);
    w.frame_session  = sess;
    w.frame_sequence = seq;
    w.frame_t1       = t1;
    return w;
  endfunction

  // entered and left at a falling edge; valid stays up for a following word
  task automatic put_word(input in_word_t w);
    while (send_idle && $urandom_range(0, 99) < 31) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain_results;
    in_valid <= 1'b0;
    @(negedge clk);
    while (words_due != 0) @(negedge clk);
  endtask

  task automatic set_config(input logic [15:0] timeout_ms, input logic [7:0] period_ms);
    cfg_write <= 1'b1;
    cfg_index <= REG_ONLINE_TIMEOUT;
    cfg_data  <= timeout_ms;
    @(negedge clk);
    cfg_index <= REG_ATTITUDE_PERIOD;
    cfg_data  <= {8'($urandom), period_ms};
    @(negedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  task automatic next_word(output in_word_t w);
    int pick;
    int step;
    int roll;
    pick = $urandom_range(0, 99);
    if (pick < 45) step = 0;
    else if (pick < 85) step = $urandom_range(1, 3);
    else if (pick < 98) step = $urandom_range(4, 20);
    else step = $urandom_range(100, 70000);
    clk_ms = clk_ms + 32'(step);
    clk_us = clk_us + 64'(step) * 64'd1000 + 64'($urandom_range(0, 999));
    roll = $urandom_range(0, 99);
    if (roll < 45) begin
      w = tick_word($urandom_range(0, 3) != 0);
    end else if (roll < 57) begin
      if ($urandom_range(0, 9) == 0) link_session = {$urandom, $urandom} | 64'd1;
      w = hello_word(link_session, $urandom);
    end else if (roll < 75) begin
      w = sync_word(link_session, $urandom, {$urandom, $urandom});
    end else if (roll < 87) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) w = legacy_word(8'd0, $urandom_range(0, 3) != 0);
      else if (pick == 1) w = legacy_word(8'($urandom_range(TX_BYTES + 1, 255)), 1'b1);
      else w = legacy_word(8'($urandom_range(1, TX_BYTES)), $urandom_range(0, 3) != 0);
    end else begin
      // noise and broken frames
      w = base_word(command_t'($urandom_range(0, 3)));
      w.frame_kind = frame_kind_t'($urandom_range(0, 3));
      pick = $urandom_range(0, 2);
      if (pick == 0) w.frame_len = 8'(HELLO_LEN);
      else if (pick == 1) w.frame_len = 8'(SYNC_LEN);
      pick = $urandom_range(0, 2);
      if (pick == 0) w.frame_session = 64'd0;
      else if (pick == 1) w.frame_session = link_session;
    end
  endtask

  task automatic run_random(input int count, input int hold_at, input int calm_until);
    in_word_t w;
    clk_ms = $urandom;
    clk_us = {$urandom, $urandom};
    for (int i = 0; i < count; i++) begin
      send_idle = (i >= calm_until);
      recv_idle = (i >= calm_until);
      if (i == hold_at) hold_reqs++;
      next_word(w);
      put_word(w);
    end
  endtask

  task automatic directed_items;
    in_word_t w;
    clk_ms = 32'hFFFF_FFF0;
    clk_us = 64'hFFFF_FFFF_FFFF_F000;
    // offline: tick drops, legacy allowed if it fits, is not empty and the uart is ready
    put_word(tick_word(1'b1));
    put_word(legacy_word(8'd1, 1'b1));
    put_word(legacy_word(8'd0, 1'b1));
    put_word(legacy_word(8'(TX_BYTES), 1'b1));
    put_word(legacy_word(8'(TX_BYTES + 1), 1'b1));
    put_word(legacy_word(8'd255, 1'b1));
    put_word(legacy_word(8'd10, 1'b0));
    put_word(sync_word(64'hFFFF_FFFF_FFFF_FFFF, 32'd1, 64'd0));
    // ignored frames
    w = hello_word(64'hFFFF_FFFF_FFFF_FFFF, 32'd2);
    w.frame_ok = 1'b0;
    put_word(w);
    put_word(hello_word(64'd0, 32'd3));
    w = hello_word(64'hFFFF_FFFF_FFFF_FFFF, 32'd4);
    w.frame_len = 8'(HELLO_LEN - 1);
    put_word(w);
    // open session, then ack with a capture across the ms wrap
    put_word(hello_word(64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF));
    put_word(tick_word(1'b0));
    clk_ms = clk_ms + 32'd20;
    put_word(tick_word(1'b1));
    put_word(sync_word(64'd1, 32'd5, 64'd7));
    w = sync_word(64'hFFFF_FFFF_FFFF_FFFF, 32'd6, 64'd8);
    w.frame_len = 8'(SYNC_LEN - 1);
    put_word(w);
    w.frame_len  = 8'(SYNC_LEN);
    w.frame_kind = KIND_OTHER;
    put_word(w);
    w.frame_kind = KIND_SPARE;
    put_word(w);
    // sync reply, attitude, legacy in and out of the idle window
    clk_us = 64'hFFFF_FFFF_FFFF_FFFF;
    put_word(sync_word(64'hFFFF_FFFF_FFFF_FFFF, 32'd0, 64'hFFFF_FFFF_FFFF_FFFF));
    clk_us = clk_us + 64'd3;
    put_word(tick_word(1'b1));
    put_word(tick_word(1'b1));
    put_word(legacy_word(8'd50, 1'b1));
    clk_ms = clk_ms + 32'd6;
    put_word(legacy_word(8'd50, 1'b1));
    // renew, then a new session restarts the transmit sequence
    put_word(hello_word(64'hFFFF_FFFF_FFFF_FFFF, 32'd7));
    put_word(hello_word(64'h8000_0000_0000_0000, 32'd9));
    put_word(base_word(CMD_UNUSED));
    clk_ms = clk_ms + 32'(ONLINE_TIMEOUT_RESET);
    put_word(tick_word(1'b1));
  endtask

  // output side: random stall, plus a long hold-off on request
  initial begin
    int   hold_left;
    int   seen;
    logic idle_now;
    out_stall = 1'b0;
    hold_left = 0;
    seen      = 0;
    forever begin
      @(posedge clk);
      idle_now = recv_idle;
      if (hold_reqs != seen) begin
        seen      = hold_reqs;
        hold_left = HOLD_CYCLES;
      end
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= idle_now && ($urandom_range(0, 99) < 31);
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin
    in_valid     = 1'b0;
    in_word      = '0;
    cfg_write    = 1'b0;
    cfg_index    = REG_ONLINE_TIMEOUT;
    cfg_data     = '0;
    send_idle    = 1'b1;
    recv_idle    = 1'b1;
    hold_reqs    = 0;
    clk_ms       = '0;
    clk_us       = '0;
    link_session = 64'h0123_4567_89AB_CDEF;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    directed_items();
    drain_results();

    set_config(16'd65535, 8'd255);
    run_random(260, 100, 0);
    drain_results();

    set_config(16'd1, 8'd1);
    run_random(260, -1, 0);
    drain_results();

    set_config(16'd0, 8'd0);
    run_random(200, -1, 0);
    drain_results();

    set_config(ONLINE_TIMEOUT_RESET, ATTITUDE_PERIOD_RESET);
    run_random(300, -1, 150);
    drain_results();

    set_config(16'($urandom_range(20, 200)), 8'($urandom_range(1, 10)));
    run_random(280, 40, 0);
    drain_results();

    repeat (8) @(negedge clk);
    if (mismatches == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/alss_pkg.sv
rtl/alss_step.sv
rtl/attitude_link_session_scheduler_unit.sv
tb/alss_link_checker.sv
tb/attitude_link_session_scheduler_unit_tb.sv
